// ===== sv/ritx_pkg.sv =====
// ----------------------------------------------------------------------------
// ritx_pkg: shared definitions for the radix integer to text block
// Types, constants and helpers used by the front end, queue and digit engine.
// ----------------------------------------------------------------------------
package ritx_pkg;

  // Field and register widths.
  localparam int unsigned ValW       = 32;
  localparam int unsigned SymW       = 8;
  localparam int unsigned CfgW       = 64;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned BaseLenW   = 5;
  localparam int unsigned NumSym     = 16;
  localparam int unsigned SymIdxW    = 4;
  localparam int unsigned MaxBaseDef = 16;

  // A 32-bit magnitude has at most 32 digits (radix two).
  localparam int unsigned MaxDigits  = 32;
  localparam int unsigned DigitCntW  = 6;
  localparam int unsigned DigitIdxW  = 5;

  // Long division handles this many dividend bits per clock.
  localparam int unsigned DivBitsPerCycle = 8;

  // Characters with a fixed meaning.
  localparam logic [SymW-1:0] ChPlus  = 8'h2B;
  localparam logic [SymW-1:0] ChMinus = 8'h2D;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_LENGTH  = 2'd0,
    CFG_SYMBOLS_LOW  = 2'd1,
    CFG_SYMBOLS_HIGH = 2'd2
  } cfg_idx_e;

  // Configuration seen by the front end and the digit engine.
  typedef struct packed {
    logic [BaseLenW-1:0]    base_len;
    logic [NumSym*SymW-1:0] syms;
  } ritx_cfg_t;

  // One queued job: sign and 32-bit magnitude.
  typedef struct packed {
    logic            neg;
    logic [ValW-1:0] mag;
  } ritx_item_t;

  // Queue status toward the front end and the back end.
  typedef struct packed {
    logic full;
    logic empty;
  } ritx_qstat_t;

  // Digit engine states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_EMIT = 2'd2
  } back_state_e;

  // Pick symbol idx out of the packed alphabet.
  function automatic logic [SymW-1:0] sym_at(input logic [NumSym*SymW-1:0] syms,
                                             input logic [SymIdxW-1:0] idx);
    sym_at = syms[idx*SymW +: SymW];
  endfunction

endpackage

// ===== sv/ritx_front.sv =====
// ----------------------------------------------------------------------------
// ritx_front: input stage and classifier
// Registers each input item, drops it when the alphabet is invalid, and
// otherwise queues its sign and magnitude for the digit engine.
// ----------------------------------------------------------------------------
module ritx_front #(
  parameter int unsigned MAX_BASE = ritx_pkg::MaxBaseDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ritx_pkg::ritx_cfg_t           cfg_i,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [ritx_pkg::ValW-1:0]     s_value_i,
  input  ritx_pkg::ritx_qstat_t         qstat_i,
  output logic                          push_o,
  output ritx_pkg::ritx_item_t          push_item_o
);

  logic                       ok_d, ok_q;
  logic                       stg_valid_q;
  logic [ritx_pkg::ValW-1:0]  stg_value_q;
  logic                       accept;
  logic                       drain;

  // Alphabet check: radix in range, no sign symbols, no repeated symbol.
  always_comb begin
    logic [ritx_pkg::SymW-1:0] si;
    ok_d = (cfg_i.base_len >= ritx_pkg::BaseLenW'(2)) &&
           (cfg_i.base_len <= ritx_pkg::BaseLenW'(MAX_BASE));
    for (int i = 0; i < ritx_pkg::NumSym; i++) begin
      si = ritx_pkg::sym_at(cfg_i.syms, ritx_pkg::SymIdxW'(i));
      if (ritx_pkg::BaseLenW'(i) < cfg_i.base_len) begin
        if (si == ritx_pkg::ChPlus || si == ritx_pkg::ChMinus) begin
          ok_d = 1'b0;
        end
        for (int j = i + 1; j < ritx_pkg::NumSym; j++) begin
          if (ritx_pkg::BaseLenW'(j) < cfg_i.base_len &&
              ritx_pkg::sym_at(cfg_i.syms, ritx_pkg::SymIdxW'(j)) == si) begin
            ok_d = 1'b0;
          end
        end
      end
    end
  end

  // The check result is registered; it settles before a staged item uses it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else begin
      ok_q <= ok_d;
    end
  end

  // The staged item leaves when queued, or at once when it is dropped.
  assign drain     = ok_q ? !qstat_i.full : 1'b1;
  assign s_ready_o = !stg_valid_q || drain;
  assign accept    = s_valid_i && s_ready_o;
  assign push_o    = stg_valid_q && ok_q && !qstat_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (accept) begin
      stg_valid_q <= 1'b1;
    end else if (drain) begin
      stg_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_value_q <= s_value_i;
    end
  end

  // Sign and two's complement magnitude; the most negative value maps to 2^31.
  assign push_item_o.neg = stg_value_q[ritx_pkg::ValW-1];
  assign push_item_o.mag = stg_value_q[ritx_pkg::ValW-1] ? (~stg_value_q + 1'b1)
                                                         : stg_value_q;

endmodule

// ===== sv/ritx_queue.sv =====
// ----------------------------------------------------------------------------
// ritx_queue: two-entry job queue
// Decouples the front end from the digit engine so each side stalls alone.
// ----------------------------------------------------------------------------
module ritx_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  ritx_pkg::ritx_item_t   push_item_i,
  input  logic                   pop_i,
  output ritx_pkg::ritx_item_t   pop_item_o,
  output ritx_pkg::ritx_qstat_t  qstat_o
);

  ritx_pkg::ritx_item_t mem_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           count_q;

  assign qstat_o.full  = (count_q == 2'd2);
  assign qstat_o.empty = (count_q == 2'd0);
  assign pop_item_o    = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== sv/ritx_back.sv =====
// ----------------------------------------------------------------------------
// ritx_back: digit engine
// Divides the magnitude by the radix repeatedly, stacks the remainders and
// sends the sign and the digit symbols most significant first.
// ----------------------------------------------------------------------------
module ritx_back #(
  parameter int unsigned MAX_BASE = ritx_pkg::MaxBaseDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ritx_pkg::ritx_cfg_t           cfg_i,
  input  ritx_pkg::ritx_qstat_t         qstat_i,
  input  ritx_pkg::ritx_item_t          pop_item_i,
  output logic                          pop_o,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [ritx_pkg::SymW-1:0]     m_char_o,
  output logic                          m_last_o
);

  localparam int unsigned DigitW = (MAX_BASE > 1) ? $clog2(MAX_BASE) : 1;
  localparam int unsigned Steps  = ritx_pkg::ValW / ritx_pkg::DivBitsPerCycle;
  localparam int unsigned StepW  = (Steps > 1) ? $clog2(Steps) : 1;

  ritx_pkg::back_state_e state_q, state_d;

  logic [ritx_pkg::ValW-1:0]      div_q;
  logic [DigitW-1:0]              rem_q;
  logic [StepW-1:0]               step_q;
  logic [ritx_pkg::DigitCntW-1:0] cnt_q;
  logic                           neg_q;
  logic [DigitW-1:0]              stk_q [ritx_pkg::MaxDigits];

  logic [ritx_pkg::ValW-1:0]      div_nx;
  logic [DigitW-1:0]              rem_nx;
  logic                           digit_done;
  logic                           conv_done;
  logic                           out_load;
  logic [DigitW-1:0]              top_digit;
  logic [ritx_pkg::SymW-1:0]      char_nx;
  logic                           last_nx;
  logic                           emit_done;

  // Eight steps of restoring long division by the radix.
  always_comb begin
    logic [DigitW:0]                        t;
    logic [DigitW:0]                        base_w;
    logic [DigitW-1:0]                      r;
    logic [ritx_pkg::DivBitsPerCycle-1:0]   qb;
    base_w = cfg_i.base_len[DigitW:0];
    r      = rem_q;
    qb     = '0;
    for (int k = 0; k < ritx_pkg::DivBitsPerCycle; k++) begin
      t = {r, div_q[ritx_pkg::ValW-1-k]};
      if (t >= base_w) begin
        t = t - base_w;
        qb[ritx_pkg::DivBitsPerCycle-1-k] = 1'b1;
      end
      r = t[DigitW-1:0];
    end
    div_nx = {div_q[ritx_pkg::ValW-ritx_pkg::DivBitsPerCycle-1:0], qb};
    rem_nx = r;
  end

  assign digit_done = (state_q == ritx_pkg::ST_DIV) && (step_q == StepW'(Steps - 1));
  assign conv_done  = digit_done &&
                      ((div_nx == '0) ||
                       (cnt_q == ritx_pkg::DigitCntW'(ritx_pkg::MaxDigits - 1)));

  // Next character: the sign first, then stacked digits newest first.
  assign top_digit = stk_q[ritx_pkg::DigitIdxW'(cnt_q - 1'b1)];
  assign char_nx   = neg_q ? ritx_pkg::ChMinus
                           : ritx_pkg::sym_at(cfg_i.syms, ritx_pkg::SymIdxW'(top_digit));
  assign last_nx   = !neg_q && (cnt_q == ritx_pkg::DigitCntW'(1));
  assign emit_done = out_load && last_nx;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ritx_pkg::ST_IDLE: begin
        if (!qstat_i.empty) begin
          state_d = ritx_pkg::ST_DIV;
        end
      end
      ritx_pkg::ST_DIV: begin
        if (conv_done) begin
          state_d = ritx_pkg::ST_EMIT;
        end
      end
      ritx_pkg::ST_EMIT: begin
        if (emit_done) begin
          state_d = ritx_pkg::ST_IDLE;
        end
      end
      default: state_d = ritx_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    pop_o    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ritx_pkg::ST_IDLE: pop_o    = !qstat_i.empty;
      ritx_pkg::ST_EMIT: out_load = !m_valid_o || m_ready_i;
      default: begin
        pop_o    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ritx_pkg::ST_IDLE;
      step_q    <= '0;
      cnt_q     <= '0;
      neg_q     <= 1'b0;
      m_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        neg_q  <= pop_item_i.neg;
        step_q <= '0;
        cnt_q  <= '0;
      end else if (state_q == ritx_pkg::ST_DIV) begin
        step_q <= step_q + 1'b1;
        if (digit_done) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end else if (out_load) begin
        if (neg_q) begin
          neg_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
      if (out_load) begin
        m_valid_o <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_o <= 1'b0;
      end
    end
  end

  // Division datapath and digit stack.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      div_q <= pop_item_i.mag;
      rem_q <= '0;
    end else if (state_q == ritx_pkg::ST_DIV) begin
      div_q <= div_nx;
      rem_q <= digit_done ? '0 : rem_nx;
    end
    if (digit_done) begin
      stk_q[ritx_pkg::DigitIdxW'(cnt_q)] <= rem_nx;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_char_o <= char_nx;
      m_last_o <= last_nx;
    end
  end

endmodule

// ===== sv/radix_integer_to_text.sv =====
// ----------------------------------------------------------------------------
// radix_integer_to_text: signed integer to text in a programmable radix
// Holds the alphabet registers and joins the front end, queue and engine.
// ----------------------------------------------------------------------------
// Usage:
//   Write base_length, symbols_low and symbols_high through the cfg_* port
//   while the block is idle. Each 32-bit signed value sent on s_axis becomes
//   a run of characters on m_axis: a '-' for negative values, then the
//   digits most significant first, with tlast on the final digit. When the
//   alphabet is invalid (radix below two or above MAX_BASE, a sign symbol,
//   or a repeated symbol) the value is consumed and nothing is sent.
// Flow:
//   A value passes through the input stage and the queue, then the engine
//   finds each digit by long division, eight dividend bits per cycle, and
//   sends the characters one by one. The division unit works on one value
//   at a time.
// Reset and stall:
//   Reset clears the alphabet registers, the queue and the output valid, but
//   not the output character. When m_axis_tready is low the current character
//   holds; the queue and the input stage fill up and then s_axis_tready drops.
// ----------------------------------------------------------------------------
module radix_integer_to_text #(
  parameter int unsigned MAX_BASE = ritx_pkg::MaxBaseDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [ritx_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ritx_pkg::CfgW-1:0]      cfg_data_i,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ritx_pkg::ValW-1:0]      s_axis_tdata,   // [31:0] value
  // Output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ritx_pkg::SymW-1:0]      m_axis_tdata,   // [7:0] char_out
  output logic                           m_axis_tlast    // last
);

  logic [ritx_pkg::BaseLenW-1:0] base_len_q;
  logic [ritx_pkg::CfgW-1:0]     sym_lo_q, sym_hi_q;
  ritx_pkg::ritx_cfg_t           cfg;
  ritx_pkg::ritx_qstat_t         qstat;
  ritx_pkg::ritx_item_t          push_item, pop_item;
  logic                          push, pop;

  // Alphabet registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_len_q <= '0;
      sym_lo_q   <= '0;
      sym_hi_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ritx_pkg::CFG_BASE_LENGTH:  base_len_q <= cfg_data_i[ritx_pkg::BaseLenW-1:0];
        ritx_pkg::CFG_SYMBOLS_LOW:  sym_lo_q   <= cfg_data_i;
        ritx_pkg::CFG_SYMBOLS_HIGH: sym_hi_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg.base_len = base_len_q;
  assign cfg.syms     = {sym_hi_q, sym_lo_q};

  ritx_front #(
    .MAX_BASE (MAX_BASE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_value_i   (s_axis_tdata),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_item_o (push_item)
  );

  ritx_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .qstat_o     (qstat)
  );

  ritx_back #(
    .MAX_BASE (MAX_BASE)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .qstat_i    (qstat),
    .pop_item_i (pop_item),
    .pop_o      (pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_char_o   (m_axis_tdata),
    .m_last_o   (m_axis_tlast)
  );

endmodule

// ===== sv/ritx_checker.sv =====
// ----------------------------------------------------------------------------
// ritx_checker: port-level checks for radix_integer_to_text
// Watches the output stream for hold rules and character sanity.
// ----------------------------------------------------------------------------
module ritx_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [ritx_pkg::SymW-1:0] m_axis_tdata,
  input logic                      m_axis_tlast
);

  // A stalled transfer keeps its valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped during stall");

  // A stalled transfer keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output payload changed during stall");

  // A plus sign is never a legal digit, so it never appears.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata != ritx_pkg::ChPlus)
    else $error("plus sign sent");

  // A minus sign is always the leading sign, never the final character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata == ritx_pkg::ChMinus |-> !m_axis_tlast)
    else $error("minus sign marked as last");

endmodule

bind radix_integer_to_text ritx_checker u_ritx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
